// ===== design/msp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg
// Shared constants for the money string parser: field widths, item kinds
// and the ASCII codes the parser recognizes.
// ----------------------------------------------------------------------------
package msp_pkg;

   localparam int unsigned MAX_CHARS_DEF = 18;

   localparam int unsigned CH_W     = 8;
   localparam int unsigned MANT_W   = 60;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned SAT_W    = 2;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_BITS   = 1 + 1 + MANT_W + COUNT_W;
   localparam int unsigned RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CH_W-1:0] CH_DOT    = 8'h2e;
   localparam logic [CH_W-1:0] CH_COMMA  = 8'h2c;
   localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CH_W-1:0] CH_MINUS  = 8'h2d;

   localparam logic [SAT_W-1:0] SAT_MAX = 2'd2;

endpackage

`default_nettype wire

// ===== design/money_string_parser_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// money_string_parser_unit
// Parses a money amount streamed one character per item, ended by an end
// marker item, into ok flag, sign, decimal mantissa and fraction digit count.
// ----------------------------------------------------------------------------
// One item per cycle unless stalled. Items sit in the input register; the
// parse update (flag logic plus a times-ten add on the mantissa) sits
// between that register and the parser state, so a character is absorbed at
// the edge after acceptance, and an end marker's result is loaded into the
// rsp register as it leaves the input register and is valid from then on.
// Only end marker items produce a result; a held result stalls the input
// only while an end marker waits in the input register, otherwise characters
// keep flowing into the parser state. Amount = mantissa / 10^frac_digits.
module money_string_parser_unit #(
   parameter int unsigned MAX_CHARS = msp_pkg::MAX_CHARS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [msp_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] ch
   input  wire logic [0:0]                      req_tuser,   // [0] op
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [msp_pkg::RSP_DATA_W-1:0]       rsp_tdata    // [0] ok, [1] negative,
                                                             // [61:2] mantissa,
                                                             // [66:62] frac_digits, rest 0
);

   localparam logic [msp_pkg::COUNT_W-1:0] MAX_CNT = msp_pkg::COUNT_W'(MAX_CHARS);

   logic                           in_valid_ff;
   logic                           in_op_ff;
   logic [msp_pkg::CH_W-1:0]       in_ch_ff;

   logic [msp_pkg::MANT_W-1:0]     acc_ff,        acc_in;
   logic [msp_pkg::COUNT_W-1:0]    char_cnt_ff,   char_cnt_in;
   logic [msp_pkg::COUNT_W-1:0]    frac_cnt_ff,   frac_cnt_in;
   logic                           digit_seen_ff, digit_seen_in;
   logic                           dot_seen_ff,   dot_seen_in;
   logic [msp_pkg::SAT_W-1:0]      paren_ff,      paren_in;
   logic [msp_pkg::SAT_W-1:0]      dollar_ff,     dollar_in;
   logic                           minus_ff,      minus_in;
   logic                           closed_ff,     closed_in;
   logic                           rejected_ff,   rejected_in;

   logic                           out_valid_ff;
   logic [msp_pkg::RSP_DATA_W-1:0] out_data_ff;

   logic                           out_free;
   logic                           stage_go;
   logic                           is_digit;
   logic [msp_pkg::MANT_W-1:0]     acc_times_ten;
   logic [msp_pkg::MANT_W-1:0]     digit_val;
   logic                           good;
   logic [msp_pkg::RSP_BITS-1:0]   result;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign stage_go   = in_valid_ff && (in_op_ff == msp_pkg::OP_CHAR || out_free);
   assign req_tready = !in_valid_ff || stage_go;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign is_digit      = (in_ch_ff >= msp_pkg::CH_ZERO) && (in_ch_ff <= msp_pkg::CH_NINE);
   assign acc_times_ten = (acc_ff << 3) + (acc_ff << 1);
   assign digit_val     = msp_pkg::MANT_W'(in_ch_ff - msp_pkg::CH_ZERO);

   always_comb begin
      acc_in        = acc_ff;
      char_cnt_in   = char_cnt_ff;
      frac_cnt_in   = frac_cnt_ff;
      digit_seen_in = digit_seen_ff;
      dot_seen_in   = dot_seen_ff;
      paren_in      = paren_ff;
      dollar_in     = dollar_ff;
      minus_in      = minus_ff;
      closed_in     = closed_ff;
      rejected_in   = rejected_ff;
      if (!rejected_ff) begin
         priority if (is_digit) begin
            if (char_cnt_ff >= MAX_CNT) begin
               rejected_in = 1'b1;
            end else begin
               char_cnt_in   = char_cnt_ff + 1'b1;
               acc_in        = acc_times_ten + digit_val;
               digit_seen_in = 1'b1;
               if (dot_seen_ff) begin
                  frac_cnt_in = frac_cnt_ff + 1'b1;
               end
            end
         end else if (in_ch_ff == msp_pkg::CH_DOT) begin
            if (dot_seen_ff || char_cnt_ff >= MAX_CNT) begin
               rejected_in = 1'b1;
            end else begin
               dot_seen_in = 1'b1;
               char_cnt_in = char_cnt_ff + 1'b1;
            end
         end else if (in_ch_ff == msp_pkg::CH_COMMA || in_ch_ff == msp_pkg::CH_SPACE) begin
            rejected_in = rejected_ff;
         end else if (in_ch_ff == msp_pkg::CH_DOLLAR) begin
            if (dollar_ff < msp_pkg::SAT_MAX) begin
               dollar_in = dollar_ff + 1'b1;
            end
         end else if (in_ch_ff == msp_pkg::CH_LPAREN) begin
            if (digit_seen_ff) begin
               rejected_in = 1'b1;
            end else if (paren_ff < msp_pkg::SAT_MAX) begin
               paren_in = paren_ff + 1'b1;
            end
         end else if (in_ch_ff == msp_pkg::CH_RPAREN) begin
            if (paren_ff != 2'd1 || !digit_seen_ff) begin
               rejected_in = 1'b1;
            end else begin
               paren_in  = '0;
               closed_in = 1'b1;
            end
         end else if (in_ch_ff == msp_pkg::CH_MINUS && !digit_seen_ff) begin
            minus_in = 1'b1;
         end else begin
            rejected_in = 1'b1;
         end
      end
   end

   assign good = !rejected_ff && digit_seen_ff && (dollar_ff <= 2'd1) && (paren_ff == '0);

   always_comb begin
      if (good) begin
         result = {frac_cnt_ff, acc_ff, (minus_ff || closed_ff), 1'b1};
      end else begin
         result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready) begin
         in_op_ff <= req_tuser[0];
         in_ch_ff <= req_tdata[msp_pkg::CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (stage_go && in_op_ff == msp_pkg::OP_END)) begin
         acc_ff        <= '0;
         char_cnt_ff   <= '0;
         frac_cnt_ff   <= '0;
         digit_seen_ff <= 1'b0;
         dot_seen_ff   <= 1'b0;
         paren_ff      <= '0;
         dollar_ff     <= '0;
         minus_ff      <= 1'b0;
         closed_ff     <= 1'b0;
         rejected_ff   <= 1'b0;
      end else if (stage_go) begin
         acc_ff        <= acc_in;
         char_cnt_ff   <= char_cnt_in;
         frac_cnt_ff   <= frac_cnt_in;
         digit_seen_ff <= digit_seen_in;
         dot_seen_ff   <= dot_seen_in;
         paren_ff      <= paren_in;
         dollar_ff     <= dollar_in;
         minus_ff      <= minus_in;
         closed_ff     <= closed_in;
         rejected_ff   <= rejected_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= stage_go && in_op_ff == msp_pkg::OP_END;
      end
      if (out_free && stage_go && in_op_ff == msp_pkg::OP_END) begin
         out_data_ff <= msp_pkg::RSP_DATA_W'(result);
      end
   end

endmodule

`default_nettype wire
